// ===== rtl/core/tsmt_pkg.sv =====
// shared types and constants of the single-finger touchpad move tracker
package tsmt_pkg;

  localparam int MaxPointers = 16;

  localparam int PidW    = 4;
  localparam int MaskW   = 16;
  localparam int PosW    = 16;
  localparam int RelW    = PosW + 1;
  localparam int StampW  = 48;
  localparam int DevW    = 16;
  localparam int ZoneW   = 16;
  localparam int CfgIdxW = 1;

  localparam int InDataW  = 120;
  localparam int OutDataW = 104;

  // only ids below MaxPointers can be listed as touching
  localparam logic [MaskW-1:0] ValidMask = (MaxPointers >= MaskW) ? {MaskW{1'b1}} :
                                           MaskW'((64'd1 << MaxPointers) - 64'd1);

  localparam logic [CfgIdxW-1:0] CfgDeadZoneX = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgDeadZoneY = 1'b1;

  typedef enum logic [1:0] {
    ActDown  = 2'd0,
    ActMove  = 2'd1,
    ActUp    = 2'd2,
    ActOther = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ModeWaiting = 2'd0,
    ModeMoving  = 2'd1,
    ModeDead    = 2'd2
  } mode_e;

  typedef struct packed {
    action_e            action;
    logic [PidW-1:0]    pointer_id;
    logic [MaskW-1:0]   touched_mask;
    logic               item_present;
    logic [PosW-1:0]    pos_x;
    logic [PosW-1:0]    pos_y;
    logic [StampW-1:0]  stamp;
    logic [DevW-1:0]    source_device;
  } item_t;

  typedef struct packed {
    logic [RelW-1:0]    rel_x;
    logic [RelW-1:0]    rel_y;
    logic [StampW-1:0]  move_time;
    logic [DevW-1:0]    move_device;
  } result_t;

  typedef struct packed {
    logic                valid;
    logic [CfgIdxW-1:0]  index;
    logic [ZoneW-1:0]    data;
  } cfg_wr_t;

endpackage

// ===== rtl/core/tsmt_in_stage.sv =====
// input register stage holding one event item
module tsmt_in_stage import tsmt_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  s_valid_i,
  output logic  s_ready_o,
  input  item_t s_item_i,
  input  logic  take_i,
  output logic  item_valid_o,
  output item_t item_o
);

  logic  valid_q, valid_d;
  item_t item_q;

  assign s_ready_o    = !valid_q || take_i;
  assign item_valid_o = valid_q;
  assign item_o       = item_q;

  always_comb begin
    valid_d = valid_q;
    if (s_valid_i && s_ready_o) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_valid_i && s_ready_o) begin
      item_q <= s_item_i;
    end
  end

endmodule

// ===== rtl/core/tsmt_tracker.sv =====
// tracking state, dead-zone registers and the per-event step logic
module tsmt_tracker import tsmt_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_wr_t cfg_i,
  input  logic    step_i,
  input  item_t   item_i,
  output logic    res_valid_o,
  output result_t res_o
);

  logic [ZoneW-1:0] dz_x_q, dz_y_q;
  mode_e            mode_q, mode_d;
  logic [PidW-1:0]  tracked_q, tracked_d;
  logic [PosW-1:0]  last_x_q, last_x_d, last_y_q, last_y_d;
  logic             latched_q, latched_d;
  logic [DevW-1:0]  dev_q, dev_d;

  logic [MaskW-1:0] mask_v, pbit, rest;
  logic             listed, mask_one, rest_one, rest_none;
  logic [PidW-1:0]  rest_idx;
  logic signed [RelW-1:0] dx, dy, zx, zy, nzx, nzy;
  logic             in_zone;

  always_comb begin
    mask_v = item_i.touched_mask & ValidMask;
    pbit   = (int'(item_i.pointer_id) < MaxPointers) ?
             (MaskW'(1) << item_i.pointer_id) : '0;
    listed = |(mask_v & pbit);
    rest   = mask_v & ~pbit;
    mask_one  = (mask_v != '0) && ((mask_v & (mask_v - MaskW'(1))) == '0);
    rest_one  = (rest != '0) && ((rest & (rest - MaskW'(1))) == '0);
    rest_none = (rest == '0);
    // rest is one-hot where its index is used
    rest_idx = '0;
    for (int i = 0; i < MaskW; i++) begin
      if (rest[i]) begin
        rest_idx = rest_idx | PidW'(i);
      end
    end
  end

  always_comb begin
    dx  = $signed({item_i.pos_x[PosW-1], item_i.pos_x}) - $signed({last_x_q[PosW-1], last_x_q});
    dy  = $signed({item_i.pos_y[PosW-1], item_i.pos_y}) - $signed({last_y_q[PosW-1], last_y_q});
    zx  = $signed({1'b0, dz_x_q});
    zy  = $signed({1'b0, dz_y_q});
    nzx = -zx;
    nzy = -zy;
    in_zone = (dx > nzx) && (dx < zx) && (dy > nzy) && (dy < zy);
  end

  always_comb begin
    mode_d      = mode_q;
    tracked_d   = tracked_q;
    last_x_d    = last_x_q;
    last_y_d    = last_y_q;
    latched_d   = latched_q;
    dev_d       = dev_q;
    res_valid_o = 1'b0;
    case (mode_q)
      ModeWaiting: begin
        if (!listed) begin
          mode_d = ModeDead;
        end else if (item_i.action == ActDown && mask_one) begin
          if (!item_i.item_present) begin
            mode_d = ModeDead;
          end else begin
            tracked_d = item_i.pointer_id;
            last_x_d  = item_i.pos_x;
            last_y_d  = item_i.pos_y;
            mode_d    = ModeMoving;
          end
        end else if (item_i.action == ActUp && rest_one) begin
          if (!item_i.item_present) begin
            mode_d = ModeDead;
          end else begin
            tracked_d = rest_idx;
            last_x_d  = item_i.pos_x;
            last_y_d  = item_i.pos_y;
            mode_d    = ModeMoving;
          end
        end
      end
      ModeMoving: begin
        if (!listed) begin
          mode_d = ModeDead;
        end else if (item_i.action == ActDown || item_i.action == ActUp) begin
          mode_d = ModeWaiting;
        end else if (item_i.action != ActMove) begin
          mode_d = ModeDead;
        end else if (!item_i.item_present || item_i.pointer_id != tracked_q) begin
          mode_d = ModeDead;
        end else begin
          if (!latched_q) begin
            latched_d = 1'b1;
            dev_d     = item_i.source_device;
          end
          if (!in_zone) begin
            last_x_d    = item_i.pos_x;
            last_y_d    = item_i.pos_y;
            res_valid_o = 1'b1;
          end
        end
      end
      default: begin
        // dead, and any stray code
        if (item_i.action == ActUp && rest_none) begin
          mode_d = ModeWaiting;
        end
      end
    endcase
  end

  always_comb begin
    res_o.rel_x       = dx;
    res_o.rel_y       = dy;
    res_o.move_time   = item_i.stamp;
    res_o.move_device = dev_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dz_x_q <= '0;
      dz_y_q <= '0;
    end else if (cfg_i.valid) begin
      if (cfg_i.index == CfgDeadZoneX) begin
        dz_x_q <= cfg_i.data;
      end
      if (cfg_i.index == CfgDeadZoneY) begin
        dz_y_q <= cfg_i.data;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= ModeWaiting;
      tracked_q <= '0;
      last_x_q  <= '0;
      last_y_q  <= '0;
      latched_q <= 1'b0;
      dev_q     <= '0;
    end else if (step_i) begin
      mode_q    <= mode_d;
      tracked_q <= tracked_d;
      last_x_q  <= last_x_d;
      last_y_q  <= last_y_d;
      latched_q <= latched_d;
      dev_q     <= dev_d;
    end
  end

  a_res_only_moving: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && res_valid_o) |-> (mode_q == ModeMoving && mode_d == ModeMoving))
    else $error("result produced outside moving mode");

  a_last_pos_follows_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && res_valid_o) |=> (last_x_q == $past(item_i.pos_x) &&
                                 last_y_q == $past(item_i.pos_y)))
    else $error("reported position not stored");

  a_latch_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    latched_q |=> (latched_q && $stable(dev_q)))
    else $error("device latch changed after being set");

  a_track_on_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && tracked_d != tracked_q) |-> (mode_q == ModeWaiting && mode_d == ModeMoving))
    else $error("tracked id changed outside tracking start");

endmodule

// ===== rtl/core/tsmt_out_stage.sv =====
// result register toward the output stream
module tsmt_out_stage import tsmt_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  result_t res_i,
  output logic    ready_o,
  output logic    m_valid_o,
  input  logic    m_ready_i,
  output result_t m_res_o
);

  logic    valid_q, valid_d;
  result_t res_q;

  assign ready_o   = !valid_q || m_ready_i;
  assign m_valid_o = valid_q;
  assign m_res_o   = res_q;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (m_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

endmodule

// ===== rtl/core/touch_single_move_tracker_unit.sv =====
// single-finger touchpad move tracker, top level
// path: an event item is held in the input register and its result in the result register
// throughput: one event item per cycle; a result waiting for m_axis_tready holds
// the step, and the input register then takes at most one more item
// reset: control state, mode, tracked pointer, stored position, device latch
// and dead-zone registers clear asynchronously on rst_ni low
module touch_single_move_tracker_unit import tsmt_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [ZoneW-1:0]    cfg_data_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // pointer_id, touched_mask, item_present, pos_x, pos_y, stamp, source_device, zero pad
  input  logic [InDataW-1:0]  s_axis_tdata,
  // action
  input  logic [1:0]          s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // rel_x, rel_y, move_time, move_device, zero pad
  output logic [OutDataW-1:0] m_axis_tdata
);

  item_t   s_item, item;
  result_t res, m_res;
  cfg_wr_t cfg;
  logic    item_valid, out_ready, step, res_valid;

  always_comb begin
    s_item.action        = action_e'(s_axis_tuser);
    s_item.pointer_id    = s_axis_tdata[3:0];
    s_item.touched_mask  = s_axis_tdata[19:4];
    s_item.item_present  = s_axis_tdata[20];
    s_item.pos_x         = s_axis_tdata[36:21];
    s_item.pos_y         = s_axis_tdata[52:37];
    s_item.stamp         = s_axis_tdata[100:53];
    s_item.source_device = s_axis_tdata[116:101];
  end

  assign cfg_ready_o = 1'b1;
  assign cfg.valid   = cfg_valid_i;
  assign cfg.index   = cfg_index_i;
  assign cfg.data    = cfg_data_i;

  assign step = item_valid && out_ready;

  tsmt_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_valid_i    (s_axis_tvalid),
    .s_ready_o    (s_axis_tready),
    .s_item_i     (s_item),
    .take_i       (out_ready),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  tsmt_tracker u_tracker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .step_i      (step),
    .item_i      (item),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  tsmt_out_stage u_out_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (step && res_valid),
    .res_i     (res),
    .ready_o   (out_ready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_res_o   (m_res)
  );

  assign m_axis_tdata = {6'b0, m_res.move_device, m_res.move_time, m_res.rel_y, m_res.rel_x};

endmodule

// ===== tb/sv/tb_touch_single_move_tracker_unit.sv =====
// testbench for the single-finger touchpad move tracker: directed mode walks, dead zones, random touch sessions
`timescale 1ns / 1ps

module tb_touch_single_move_tracker_unit;
  import tsmt_pkg::*;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [ZoneW-1:0]    cfg_data_i;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  // pointer_id, touched_mask, item_present, pos_x, pos_y, stamp, source_device, zero pad
  logic [InDataW-1:0]  s_axis_tdata;
  // action
  logic [1:0]          s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  // rel_x, rel_y, move_time, move_device, zero pad
  logic [OutDataW-1:0] m_axis_tdata;

  touch_single_move_tracker_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  localparam int DrainCycles = 8;

  // tracker copy
  mode_e                  trk_mode;
  logic [PidW-1:0]        trk_id;
  logic signed [PosW-1:0] trk_last_x;
  logic signed [PosW-1:0] trk_last_y;
  bit                     trk_dev_latched;
  logic [DevW-1:0]        trk_dev;
  logic [ZoneW-1:0]       zone_x;
  logic [ZoneW-1:0]       zone_y;

  result_t expected_moves[$];
  bit      idle_on;
  int      errors;
  int      n_sent;
  int      n_moves;
  int      n_phases;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #2ms;
    $display("timeout at %0t", $time);
    $display("status: fail");
    $finish;
  end

  function automatic void track_event(input item_t it);
    logic [MaskW-1:0] mask;
    logic [MaskW-1:0] pbit;
    logic [MaskW-1:0] rest;
    logic [PidW-1:0]  low_id;
    bit               listed;
    int               dx;
    int               dy;
    int               zx;
    int               zy;
    result_t          r;
    mask   = it.touched_mask & ValidMask;
    pbit   = (int'(it.pointer_id) < MaxPointers) ? (MaskW'(1) << it.pointer_id) : '0;
    listed = |(mask & pbit);
    rest   = mask & ~pbit;
    low_id = '0;
    for (int i = MaskW - 1; i >= 0; i--) begin
      if (rest[i]) low_id = PidW'(i);
    end
    case (trk_mode)
      ModeWaiting: begin
        if (!listed) begin
          trk_mode = ModeDead;
        end else if (it.action == ActDown && $countones(mask) == 1) begin
          if (!it.item_present) begin
            trk_mode = ModeDead;
          end else begin
            trk_id     = it.pointer_id;
            trk_last_x = it.pos_x;
            trk_last_y = it.pos_y;
            trk_mode   = ModeMoving;
          end
        end else if (it.action == ActUp && $countones(rest) == 1) begin
          // a lift leaves one finger: follow the one that stays
          if (!it.item_present) begin
            trk_mode = ModeDead;
          end else begin
            trk_id     = low_id;
            trk_last_x = it.pos_x;
            trk_last_y = it.pos_y;
            trk_mode   = ModeMoving;
          end
        end
      end
      ModeMoving: begin
        if (!listed) begin
          trk_mode = ModeDead;
        end else if (it.action == ActDown || it.action == ActUp) begin
          trk_mode = ModeWaiting;
        end else if (it.action != ActMove) begin
          trk_mode = ModeDead;
        end else if (!it.item_present || it.pointer_id != trk_id) begin
          trk_mode = ModeDead;
        end else begin
          if (!trk_dev_latched) begin
            trk_dev_latched = 1'b1;
            trk_dev         = it.source_device;
          end
          dx = int'($signed(it.pos_x)) - int'(trk_last_x);
          dy = int'($signed(it.pos_y)) - int'(trk_last_y);
          zx = int'(zone_x);
          zy = int'(zone_y);
          // suppressed only when both deltas sit strictly inside the zone
          if (!(dx > -zx && dx < zx && dy > -zy && dy < zy)) begin
            trk_last_x    = it.pos_x;
            trk_last_y    = it.pos_y;
            r.rel_x       = RelW'(dx);
            r.rel_y       = RelW'(dy);
            r.move_time   = it.stamp;
            r.move_device = trk_dev;
            expected_moves.push_back(r);
          end
        end
      end
      default: begin
        if (it.action == ActUp && rest == '0) trk_mode = ModeWaiting;
      end
    endcase
  endfunction

  function automatic item_t make_event(input action_e act, input int pid, input int mask,
                                       input bit present, input int x, input int y);
    item_t it;
    it.action        = act;
    it.pointer_id    = PidW'(pid);
    it.touched_mask  = MaskW'(mask);
    it.item_present  = present;
    it.pos_x         = PosW'(x);
    it.pos_y         = PosW'(y);
    it.stamp         = StampW'({$urandom(), $urandom()});
    it.source_device = DevW'($urandom());
    return it;
  endfunction

  task automatic send_event(input item_t it);
    while (idle_on && $urandom_range(99) < 13) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, it.source_device, it.stamp, it.pos_y, it.pos_x,
                      it.item_present, it.touched_mask, it.pointer_id};
    s_axis_tuser  <= it.action;
    do @(posedge clk_i); while (!s_axis_tready);
    track_event(it);
    n_sent++;
  endtask

  // stream goes quiet, every result comes back, then the pipe is allowed to settle
  task automatic drain_moves();
    s_axis_tvalid <= 1'b0;
    while (expected_moves.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic set_dead_zone(input int zx, input int zy);
    drain_moves();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CfgDeadZoneX;
    cfg_data_i  <= ZoneW'(zx);
    do @(posedge clk_i); while (!cfg_ready_o);
    zone_x = ZoneW'(zx);
    cfg_index_i <= CfgDeadZoneY;
    cfg_data_i  <= ZoneW'(zy);
    do @(posedge clk_i); while (!cfg_ready_o);
    zone_y = ZoneW'(zy);
    cfg_valid_i <= 1'b0;
    n_phases++;
  endtask

  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.rel_x       = m_axis_tdata[16:0];
      got.rel_y       = m_axis_tdata[33:17];
      got.move_time   = m_axis_tdata[81:34];
      got.move_device = m_axis_tdata[97:82];
      if (expected_moves.size() == 0) begin
        $display("%0t: move result expected none actual %h", $time, got);
        errors++;
      end else begin
        want = expected_moves.pop_front();
        n_moves++;
        if (got.rel_x != want.rel_x) begin
          $display("%0t: rel_x expected %h actual %h", $time, want.rel_x, got.rel_x);
          errors++;
        end
        if (got.rel_y != want.rel_y) begin
          $display("%0t: rel_y expected %h actual %h", $time, want.rel_y, got.rel_y);
          errors++;
        end
        if (got.move_time != want.move_time) begin
          $display("%0t: move_time expected %h actual %h", $time, want.move_time,
                   got.move_time);
          errors++;
        end
        if (got.move_device != want.move_device) begin
          $display("%0t: move_device expected %h actual %h", $time, want.move_device,
                   got.move_device);
          errors++;
        end
      end
    end
    m_axis_tready <= idle_on ? ($urandom_range(99) >= 13) : 1'b1;
  end

  task automatic test_mode_transitions();
    send_event(make_event(ActMove, 0, 16'h0000, 1, 0, 0));            // unlisted in waiting
    send_event(make_event(ActUp, 0, 16'h0001, 1, 0, 0));              // last lift in dead
    send_event(make_event(ActDown, 15, 16'h8000, 0, 5, 5));           // down without item data
    send_event(make_event(ActUp, 15, 16'h8000, 1, 0, 0));
    send_event(make_event(ActDown, 15, 16'h8000, 1, 32767, 32767));
    send_event(make_event(ActMove, 15, 16'h8000, 1, -32768, -32768)); // largest negative delta
    send_event(make_event(ActMove, 15, 16'hFFFF, 1, 32767, 32767));   // largest positive delta
    send_event(make_event(ActMove, 15, 16'h8000, 1, 32767, 32767));   // zero delta, zone zero
    send_event(make_event(ActOther, 15, 16'h8000, 1, 0, 0));
    send_event(make_event(ActDown, 3, 16'h0009, 1, 0, 0));
    send_event(make_event(ActUp, 3, 16'h0009, 1, 0, 0));              // a finger stays, still dead
    send_event(make_event(ActUp, 0, 16'h0001, 1, 0, 0));
    send_event(make_event(ActUp, 2, 16'h0024, 1, -100, 200));         // follow remaining pointer
    send_event(make_event(ActMove, 5, 16'hFFFF, 1, -90, 150));
    send_event(make_event(ActMove, 2, 16'h0024, 1, 0, 0));            // not the tracked pointer
    send_event(make_event(ActUp, 2, 16'h0004, 1, 0, 0));
    send_event(make_event(ActDown, 7, 16'h0081, 1, 0, 0));            // two down, keep waiting
    send_event(make_event(ActUp, 7, 16'h0081, 0, 0, 0));              // lift without item data
    send_event(make_event(ActUp, 0, 16'h0001, 1, 0, 0));
    send_event(make_event(ActDown, 1, 16'h0002, 1, 10, 10));
    send_event(make_event(ActMove, 1, 16'h0002, 0, 20, 20));          // move without item data
    send_event(make_event(ActUp, 1, 16'h0002, 1, 0, 0));
    send_event(make_event(ActDown, 4, 16'h0010, 1, 1, 1));
    send_event(make_event(ActDown, 6, 16'h0050, 1, 2, 2));            // second finger in moving
    send_event(make_event(ActUp, 6, 16'h0050, 1, 3, 3));
    send_event(make_event(ActMove, 4, 16'h0000, 1, 4, 4));            // tracked pointer unlisted
    send_event(make_event(ActUp, 4, 16'h0010, 1, 0, 0));
  endtask

  task automatic test_dead_zone_edges();
    set_dead_zone(10, 10);
    send_event(make_event(ActDown, 9, 16'h0200, 1, 0, 0));
    send_event(make_event(ActMove, 9, 16'h0200, 1, 9, -9));   // inside on both axes
    send_event(make_event(ActMove, 9, 16'h0200, 1, 10, 0));   // on the edge in x
    send_event(make_event(ActMove, 9, 16'h0200, 1, 10, -10)); // on the edge in y
    send_event(make_event(ActMove, 9, 16'h0200, 1, 1, -1));   // inside, position kept
    send_event(make_event(ActUp, 9, 16'h0200, 1, 0, 0));
    set_dead_zone(65535, 65535);
    send_event(make_event(ActDown, 0, 16'h0001, 1, -32768, 0));
    send_event(make_event(ActMove, 0, 16'h0001, 1, 32767, 0));
    send_event(make_event(ActMove, 0, 16'h0001, 1, -32768, 0));
    send_event(make_event(ActUp, 0, 16'h0001, 1, 0, 0));
  endtask

  // one finger session with random content, sometimes broken on purpose or handed to a second finger
  task automatic run_session(input int span);
    int p;
    int q;
    int x;
    int y;
    int n;
    int extra;
    bit broken;
    p = $urandom_range(15);
    x = $signed(16'($urandom()));
    y = $signed(16'($urandom()));
    send_event(make_event(ActDown, p, 1 << p, $urandom_range(19) != 0, x, y));
    n = $urandom_range(2, 10);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 30) begin
        x = $signed(16'($urandom()));
        y = $signed(16'($urandom()));
      end else begin
        x = $signed(16'(x + $signed($urandom_range(2 * span)) - span));
        y = $signed(16'(y + $signed($urandom_range(2 * span)) - span));
      end
      extra  = ($urandom_range(3) == 0) ? int'($urandom_range(16'hFFFF)) : 0;
      broken = ($urandom_range(24) == 0);
      if (broken && $urandom_range(1))
        send_event(make_event(ActMove, (p + 1) % 16, (1 << p) | (1 << ((p + 1) % 16)), 1, x, y));
      else
        send_event(make_event(ActMove, p, (1 << p) | extra, !broken, x, y));
    end
    if ($urandom_range(2) == 0) begin
      // second finger comes and the first one leaves
      q = (p + $urandom_range(1, 15)) % 16;
      send_event(make_event(ActDown, q, (1 << p) | (1 << q), 1, x, y));
      send_event(make_event(ActUp, p, (1 << p) | (1 << q), 1, x + 3, y - 3));
      n = $urandom_range(1, 5);
      for (int i = 0; i < n; i++) begin
        x = $signed(16'(x + $signed($urandom_range(2 * span)) - span));
        y = $signed(16'(y + $signed($urandom_range(2 * span)) - span));
        send_event(make_event(ActMove, q, 1 << q, 1, x, y));
      end
      p = q;
    end
    send_event(make_event(ActUp, p, 1 << p, 1, x, y));
  endtask

  task automatic run_random_phase(input int zx, input int zy, input int n_items);
    int stop_at;
    int span;
    item_t it;
    set_dead_zone(zx, zy);
    span = ((zx > zy) ? zx : zy) * 2 + 4;
    if (span > 32767) span = 32767;
    stop_at = n_sent + n_items;
    while (n_sent < stop_at) begin
      if ($urandom_range(99) < 85) begin
        run_session(span);
      end else begin
        repeat ($urandom_range(1, 3)) begin
          it = make_event(action_e'($urandom_range(3)), $urandom_range(15),
                          $urandom_range(16'hFFFF), 1'($urandom_range(1)),
                          $urandom_range(16'hFFFF), $urandom_range(16'hFFFF));
          send_event(it);
        end
      end
    end
  endtask

  task automatic test_random_traffic();
    run_random_phase(0, 0, 180);
    idle_on = 1'b0;
    run_random_phase(1, 1, 180);
    idle_on = 1'b1;
    run_random_phase($urandom_range(1, 300), $urandom_range(1, 300), 180);
    run_random_phase(0, 65535, 180);
    run_random_phase(65535, 65535, 180);
  endtask

  initial begin
    rst_ni        <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= CfgDeadZoneX;
    cfg_data_i    <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= ActDown;
    trk_mode        = ModeWaiting;
    trk_id          = '0;
    trk_last_x      = '0;
    trk_last_y      = '0;
    trk_dev_latched = 1'b0;
    trk_dev         = '0;
    zone_x          = '0;
    zone_y          = '0;
    idle_on         = 1'b1;
    errors          = 0;
    n_sent          = 0;
    n_moves         = 0;
    n_phases        = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_mode_transitions();
    test_dead_zone_edges();
    test_random_traffic();
    drain_moves();
    $display("covered %0d touch events and %0d move results over %0d dead-zone settings",
             n_sent, n_moves, n_phases);
    $display("mode walks, dead-zone edges and random sessions with stalls on both sides");
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
